FILE: hdl/c_subset_lexer_top_macros.svh
// Assertion macros used by the lexer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef C_SUBSET_LEXER_TOP_MACROS_SVH
`define C_SUBSET_LEXER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CSLEX_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cslex: same-cycle check failed");
`define CSLEX_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cslex: next-cycle check failed");
`else
`define CSLEX_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define CSLEX_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/cslex_pkg.sv
// Types, constants and byte-class functions of the C subset lexer.
// No dependencies; used by cslex_core and c_subset_lexer_top.
package cslex_pkg;

   localparam int LINE_WIDTH   = 24;
   localparam int OFFSET_WIDTH = 32;
   localparam int LEN_WIDTH    = 16;
   localparam int KW_COUNT     = 13;
   localparam int PREFIX_BYTES = 8;

   localparam int RSP_FIELDS_W = 4 + 8 + 8 + LINE_WIDTH + OFFSET_WIDTH + LEN_WIDTH;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_EQ    = 8'h3D;

   typedef enum logic [3:0] {
      KIND_EOF      = 4'd0,
      KIND_IDENT    = 4'd1,
      KIND_KEYWORD  = 4'd2,
      KIND_NUMBER   = 4'd3,
      KIND_OPER     = 4'd4,
      KIND_SEMI     = 4'd5,
      KIND_LPAREN   = 4'd6,
      KIND_RPAREN   = 4'd7,
      KIND_LBRACE   = 4'd8,
      KIND_RBRACE   = 4'd9,
      KIND_LBRACKET = 4'd10,
      KIND_RBRACKET = 4'd11,
      KIND_COMMA    = 4'd12
   } kind_type;

   // keywords packed first byte highest, in keyword index order
   localparam logic [63:0] KW_TABLE [KW_COUNT] = '{
      64'h6966,             // if
      64'h656c7365,         // else
      64'h7768696c65,       // while
      64'h666f72,           // for
      64'h72657475726e,     // return
      64'h627265616b,       // break
      64'h636f6e74696e7565, // continue
      64'h737472756374,     // struct
      64'h696e74,           // int
      64'h666c6f6174,       // float
      64'h63686172,         // char
      64'h646f75626c65,     // double
      64'h766f6964          // void
   };

   typedef struct packed {
      kind_type                  kind;
      logic [3:0]                kw;
      logic [7:0]                op1;
      logic [7:0]                op2;
      logic [LINE_WIDTH-1:0]     line;
      logic [OFFSET_WIDTH-1:0]   off;
      logic [LEN_WIDTH-1:0]      len;
      logic                      last;
   } rec_type;

   typedef struct packed {
      logic [1:0] count;
      rec_type    rec0;
      rec_type    rec1;
   } rec_pair_type;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= 8'h30 && b <= 8'h39;
   endfunction

   function automatic logic may_pair(input logic [7:0] b);
      return b == 8'h3D || b == 8'h21 || b == 8'h3C || b == 8'h3E ||
             b == 8'h26 || b == 8'h7C || b == 8'h2B || b == 8'h2D;
   endfunction

   function automatic logic pairs(input logic [7:0] a, input logic [7:0] b);
      logic same;
      same = (a == b) && (a == 8'h3C || a == 8'h3E || a == 8'h26 ||
                          a == 8'h7C || a == 8'h2B || a == 8'h2D);
      if (b == CH_EQ) begin
         return a == 8'h3D || a == 8'h21 || a == 8'h3C || a == 8'h3E;
      end
      return same;
   endfunction

   // KIND_EOF means not a punctuation byte
   function automatic kind_type punct_kind(input logic [7:0] b);
      kind_type k;
      case (b)
         8'h3B:   k = KIND_SEMI;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h5B:   k = KIND_LBRACKET;
         8'h5D:   k = KIND_RBRACKET;
         8'h2C:   k = KIND_COMMA;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

   function automatic rec_type make_rec(input kind_type kind, input logic [3:0] kw,
                                        input logic [7:0] op1, input logic [7:0] op2,
                                        input logic [LINE_WIDTH-1:0] line,
                                        input logic [OFFSET_WIDTH-1:0] off,
                                        input logic [LEN_WIDTH-1:0] len);
      rec_type r;
      r.kind = kind;
      r.kw   = kw;
      r.op1  = op1;
      r.op2  = op2;
      r.line = line;
      r.off  = off;
      r.len  = len;
      r.last = 1'b0;
      return r;
   endfunction

endpackage

FILE: hdl/c_subset_lexer_top.sv
// Top level of the C subset lexer: stream ports and a four-entry token queue.
// Depends on cslex_pkg, cslex_core and c_subset_lexer_top_macros.svh.
//
//   channel | dir | words                      | ready rule
//   req     | in  | one source byte            | queue has room for two records
//   rsp     | out | one token record           | queue not empty
//
// A byte is scanned in the cycle it is taken; its records enter the queue at that edge
// and can leave on the next cycle, so a byte can be taken every cycle while the result
// side drains. The queue sets the rate: a byte that makes two records needs one output
// transfer per record. Reset is synchronous and empties the queue.
// A stall on rsp fills the queue and then drops req_tready.
`include "c_subset_lexer_top_macros.svh"
module c_subset_lexer_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // source_byte
   input  logic                                 req_tlast,  // end_of_input
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // keyword_index, op_first, op_second, start_line, start_offset, text_length, zero pad
   output logic [cslex_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [3:0]                           rsp_tuser,  // token_kind
   output logic                                 rsp_tlast   // last_of_run
);
   import cslex_pkg::*;

   rec_pair_type          recs;
   rec_type               fifo_ff [FIFO_DEPTH];
   rec_type               head;
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  req_fire, rsp_fire;

   assign req_tready = count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = count_ff != '0;
   assign rsp_fire   = rsp_tvalid && rsp_tready;

   cslex_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_fire),
      .item_byte  (req_tdata),
      .item_end   (req_tlast),
      .recs       (recs)
   );

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(recs.count);
         count_in  = count_ff + FIFO_CNT_W'(recs.count);
      end
      rd_ptr_in = rsp_fire ? rd_ptr_ff + FIFO_PTR_W'(1) : rd_ptr_ff;
      if (rsp_fire) begin
         count_in = count_in - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && recs.count != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= recs.rec0;
      end
      if (req_fire && recs.count == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= recs.rec1;
      end
   end

   assign head      = fifo_ff[rd_ptr_ff];
   assign rsp_tdata = RSP_TDATA_W'({head.len, head.off, head.line, head.op2, head.op1,
                                    head.kw});
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   `CSLEX_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= FIFO_CNT_W'(FIFO_DEPTH))
   `CSLEX_ASSERT_NXT(a_eof_queued, clock, reset, req_fire && req_tlast, rsp_tvalid)
   `CSLEX_ASSERT_NXT(a_count_hold, clock, reset, !req_fire && !rsp_fire, $stable(count_ff))

endmodule

FILE: hdl/cslex_core.sv
// Lexer scan state and per-byte token logic; one byte per cycle.
// Depends on cslex_pkg; gives up to two token records per accepted byte.
module cslex_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  logic [7:0]              item_byte,
   input  logic                    item_end,
   output cslex_pkg::rec_pair_type recs
);
   import cslex_pkg::*;

   typedef enum logic [2:0] {
      M_IDLE, M_IDENT, M_NUMBER, M_OPER, M_SLASH, M_LCOMM, M_BCOMM
   } mode_type;

   localparam logic [LINE_WIDTH-1:0] LINE_MAX = '1;
   localparam logic [LEN_WIDTH-1:0]  LEN_MAX  = '1;

   mode_type                mode_ff, mode_in;
   logic [7:0]              pend_ff, pend_in;
   logic [LINE_WIDTH-1:0]   line_ff, line_in;
   logic [OFFSET_WIDTH-1:0] offset_ff, offset_in;
   logic [LINE_WIDTH-1:0]   tok_line_ff, tok_line_in;
   logic [OFFSET_WIDTH-1:0] tok_off_ff, tok_off_in;
   logic [LEN_WIDTH-1:0]    tok_len_ff, tok_len_in;
   logic [63:0]             prefix_ff, prefix_in;
   logic                    star_ff, star_in;

   logic [LINE_WIDTH-1:0] line_inc;
   logic [LEN_WIDTH-1:0]  len_inc;
   logic                  kw_hit;
   logic [3:0]            kw_idx;
   logic                  flush_v, fresh_v, a_v, b_v, do_fresh, do_grow;
   rec_type               flush_rec, fresh_rec, a_rec, b_rec, eof_rec;
   kind_type              pk;
   logic [7:0]            b;

   assign b        = item_byte;
   assign line_inc = (line_ff == LINE_MAX) ? line_ff : line_ff + LINE_WIDTH'(1);
   assign len_inc  = (tok_len_ff == LEN_MAX) ? tok_len_ff : tok_len_ff + LEN_WIDTH'(1);
   assign pk       = punct_kind(b);

   always_comb begin
      kw_hit = 1'b0;
      kw_idx = 4'd0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (!kw_hit && prefix_ff == KW_TABLE[k]) begin
            kw_hit = 1'b1;
            kw_idx = 4'(k);
         end
      end
      if (tok_len_ff > LEN_WIDTH'(PREFIX_BYTES)) begin
         kw_hit = 1'b0;
         kw_idx = 4'd0;
      end
   end

   always_comb begin
      flush_v   = 1'b1;
      flush_rec = make_rec(KIND_IDENT, 4'd0, 8'd0, 8'd0, tok_line_ff, tok_off_ff, tok_len_ff);
      unique case (mode_ff)
         M_IDENT: begin
            if (kw_hit) begin
               flush_rec.kind = KIND_KEYWORD;
               flush_rec.kw   = kw_idx;
            end
         end
         M_NUMBER: flush_rec.kind = KIND_NUMBER;
         M_OPER: begin
            flush_rec.kind = KIND_OPER;
            flush_rec.op1  = pend_ff;
            flush_rec.len  = LEN_WIDTH'(1);
         end
         M_SLASH: begin
            flush_rec.kind = KIND_OPER;
            flush_rec.op1  = CH_SLASH;
            flush_rec.len  = LEN_WIDTH'(1);
         end
         default: flush_v = 1'b0;
      endcase
   end

   always_comb begin
      eof_rec = make_rec(KIND_EOF, 4'd0, 8'd0, 8'd0, line_ff, offset_ff, LEN_WIDTH'(0));
      fresh_v = 1'b0;
      fresh_rec = make_rec(KIND_OPER, 4'd0, b, 8'd0, line_ff, offset_ff, LEN_WIDTH'(1));
      do_fresh = 1'b0;
      do_grow  = 1'b0;
      a_v = 1'b0;
      b_v = 1'b0;
      a_rec = flush_rec;
      b_rec = fresh_rec;

      mode_in     = mode_ff;
      pend_in     = pend_ff;
      line_in     = line_ff;
      offset_in   = offset_ff + OFFSET_WIDTH'(1);
      tok_line_in = tok_line_ff;
      tok_off_in  = tok_off_ff;
      tok_len_in  = tok_len_ff;
      prefix_in   = prefix_ff;
      star_in     = star_ff;

      if (item_end) begin
         a_v       = flush_v;
         b_v       = 1'b1;
         b_rec     = eof_rec;
         mode_in   = M_IDLE;
         star_in   = 1'b0;
         offset_in = offset_ff;
      end else begin
         unique case (mode_ff)
            M_IDENT: begin
               if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
                  do_grow = 1'b1;
               end else begin
                  do_fresh = 1'b1;
               end
            end
            M_NUMBER: begin
               if (is_digit(b) || b == CH_DOT) begin
                  do_grow = 1'b1;
               end else begin
                  do_fresh = 1'b1;
               end
            end
            M_OPER: begin
               if (pairs(pend_ff, b)) begin
                  a_v       = 1'b1;
                  a_rec.op2 = b;
                  a_rec.len = LEN_WIDTH'(2);
                  mode_in   = M_IDLE;
               end else begin
                  do_fresh = 1'b1;
               end
            end
            M_SLASH: begin
               if (b == CH_SLASH) begin
                  mode_in = M_LCOMM;
               end else if (b == CH_STAR) begin
                  mode_in = M_BCOMM;
                  star_in = 1'b0;
               end else begin
                  do_fresh = 1'b1;
               end
            end
            M_LCOMM: begin
               if (b == CH_LF) begin
                  line_in = line_inc;
                  mode_in = M_IDLE;
               end
            end
            M_BCOMM: begin
               if (b == CH_LF) begin
                  line_in = line_inc;
               end
               if (star_ff && b == CH_SLASH) begin
                  mode_in = M_IDLE;
                  star_in = 1'b0;
               end else begin
                  star_in = (b == CH_STAR);
               end
            end
            default: do_fresh = 1'b1;
         endcase
      end

      if (do_grow) begin
         tok_len_in = len_inc;
         if (len_inc <= LEN_WIDTH'(PREFIX_BYTES)) begin
            prefix_in = {prefix_ff[55:0], b};
         end
      end

      if (do_fresh) begin
         a_v     = flush_v;
         mode_in = M_IDLE;
         if (is_space(b)) begin
            if (b == CH_LF) begin
               line_in = line_inc;
            end
         end else if (b == CH_SLASH) begin
            mode_in = M_SLASH;
         end else if (is_alpha(b) || b == CH_UNDER) begin
            mode_in   = M_IDENT;
            prefix_in = {56'd0, b};
         end else if (is_digit(b)) begin
            mode_in = M_NUMBER;
         end else if (pk != KIND_EOF) begin
            fresh_v        = 1'b1;
            fresh_rec.kind = pk;
         end else if (may_pair(b)) begin
            mode_in = M_OPER;
            pend_in = b;
         end else begin
            fresh_v = 1'b1;
         end
         if (mode_in != M_IDLE) begin
            tok_line_in = line_ff;
            tok_off_in  = offset_ff;
            tok_len_in  = LEN_WIDTH'(1);
         end
         b_v   = fresh_v;
         b_rec = fresh_rec;
      end

      recs.count = {1'b0, a_v} + {1'b0, b_v};
      recs.rec0  = a_v ? a_rec : b_rec;
      recs.rec1  = b_rec;
      recs.rec0.last = !(a_v && b_v);
      recs.rec1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= M_IDLE;
         pend_ff     <= 8'd0;
         line_ff     <= LINE_WIDTH'(1);
         offset_ff   <= '0;
         tok_line_ff <= LINE_WIDTH'(1);
         tok_off_ff  <= '0;
         tok_len_ff  <= '0;
         prefix_ff   <= '0;
         star_ff     <= 1'b0;
      end else if (item_valid) begin
         mode_ff     <= mode_in;
         pend_ff     <= pend_in;
         line_ff     <= line_in;
         offset_ff   <= offset_in;
         tok_line_ff <= tok_line_in;
         tok_off_ff  <= tok_off_in;
         tok_len_ff  <= tok_len_in;
         prefix_ff   <= prefix_in;
         star_ff     <= star_in;
      end
   end

endmodule
